/* hdl/clk_pr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the second-chance clock page replacement block.
// Used by clk_pr_cell and clock_page_replacement; depends on nothing else.
package clk_pr_pkg;

  // Default sizes of the frame row and of a stored page number.
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths.
  localparam int CFG_W   = 5;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 4;
  localparam int TOTAL_W = 32;

  // Reset value of the active frame count register.
  localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;

  // Saturation value of the fault counter.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Found flags that ripple along the cell row: hit, empty frame,
  // unreferenced frame at or after the hand, unreferenced frame anywhere.
  typedef struct packed {
    logic hit;
    logic emp;
    logic hi;
    logic cand;
  } chain_t;

  // Update applied to the row once per request.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } op_t;

  typedef struct packed {
    logic upd;
    op_t  op;
    logic no_cand;
  } cmd_t;

endpackage

/* hdl/clk_pr_cell.sv */
`timescale 1ns / 1ps
// One frame of the clock row: page tag, occupied bit and reference bit.
// Depends on clk_pr_pkg for the chain and command types.
module clk_pr_cell #(
  parameter int INDEX = 0,
  parameter int PB    = clk_pr_pkg::PAGE_BITS_DEF,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  clk_pr_pkg::chain_t  chain_i,
  output clk_pr_pkg::chain_t  chain_o,
  output clk_pr_pkg::chain_t  sel_o,
  output logic [PB-1:0]       page_o,
  input  logic [PB-1:0]       req_page,
  input  logic [CNT_W-1:0]    n_act,
  input  logic [IDX_W-1:0]    hand,
  input  logic [IDX_W-1:0]    victim,
  input  clk_pr_pkg::cmd_t    cmd
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [PB-1:0] page_r;
  logic          occ_r;
  logic          ref_r;
  logic          ref_nxt;
  logic          occ_nxt;
  logic          active;
  logic          match;
  logic          empty;
  logic          cand;
  logic          hi_cand;
  logic          me;
  logic          in_range;
  logic          load;

  // Local flags of this frame.
  assign active  = MY_CNT < n_act;
  assign match   = active && occ_r && (page_r == req_page);
  assign empty   = active && !occ_r;
  assign cand    = active && !ref_r;
  assign hi_cand = cand && (MY_IDX >= hand);

  // A cell wins a search when it qualifies and no lower cell has.
  assign sel_o.hit  = match   && !chain_i.hit;
  assign sel_o.emp  = empty   && !chain_i.emp;
  assign sel_o.hi   = hi_cand && !chain_i.hi;
  assign sel_o.cand = cand    && !chain_i.cand;

  assign chain_o.hit  = chain_i.hit  || match;
  assign chain_o.emp  = chain_i.emp  || empty;
  assign chain_o.hi   = chain_i.hi   || hi_cand;
  assign chain_o.cand = chain_i.cand || cand;

  assign page_o = page_r;

  // Frames the hand passes on its way to the victim lose their reference bit.
  assign me = (MY_IDX == victim);
  always_comb begin
    if (cmd.no_cand) begin
      in_range = active;
    end else if (victim >= hand) begin
      in_range = active && (MY_IDX >= hand) && (MY_IDX < victim);
    end else begin
      in_range = active && ((MY_IDX >= hand) || (MY_IDX < victim));
    end
  end

  // Next state of the control bits.
  always_comb begin
    ref_nxt = ref_r;
    occ_nxt = occ_r;
    load    = 1'b0;
    if (cmd.upd) begin
      case (cmd.op)
        clk_pr_pkg::OP_HIT: begin
          if (me) ref_nxt = 1'b1;
        end
        clk_pr_pkg::OP_FILL: begin
          if (me) begin
            ref_nxt = 1'b1;
            occ_nxt = 1'b1;
            load    = 1'b1;
          end
        end
        clk_pr_pkg::OP_EVICT: begin
          if (me) begin
            ref_nxt = 1'b1;
            occ_nxt = 1'b1;
            load    = 1'b1;
          end else if (in_range) begin
            ref_nxt = 1'b0;
          end
        end
        default: begin
          ref_nxt = ref_r;
        end
      endcase
    end
  end

  // Control bits clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ref_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      ref_r <= ref_nxt;
    end
  end

  // The page tag is only read while the frame is occupied.
  always_ff @(posedge clk) begin
    if (load) page_r <= req_page;
  end

endmodule

/* hdl/clock_page_replacement.sv */
`timescale 1ns / 1ps
// Second-chance clock page replacement over a row of frame cells.
// A request is captured in the request register and its result in the output
// register; in_stall stays high while the request register holds a request,
// so no new request is taken until the cell row has searched and updated.
// Reset (synchronous, rst_n low) empties all frames, clears the hand and the
// fault count and sets the active frame count to 16. Depends on clk_pr_pkg.
module clock_page_replacement #(
  parameter int FRAMES    = clk_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = clk_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [clk_pr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [clk_pr_pkg::PAGE_W-1:0]    in_page,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_fault,
  output logic [clk_pr_pkg::FRAME_W-1:0]   out_frame,
  output logic                             out_evicted_valid,
  output logic [clk_pr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [clk_pr_pkg::TOTAL_W-1:0]   out_fault_total
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [clk_pr_pkg::CFG_W-1:0]   fiu_r;
  logic                           req_valid_r;
  logic [PAGE_BITS-1:0]           req_page_r;
  logic [IDX_W-1:0]               hand_r;
  logic [IDX_W-1:0]               hand_nxt;
  logic [clk_pr_pkg::TOTAL_W-1:0] fcnt_r;
  logic [clk_pr_pkg::TOTAL_W-1:0] fcnt_nxt;

  logic                           out_valid_r;
  logic                           out_fault_r;
  logic [clk_pr_pkg::FRAME_W-1:0] out_frame_r;
  logic                           out_ev_r;
  logic [clk_pr_pkg::PAGE_W-1:0]  out_evp_r;
  logic [clk_pr_pkg::TOTAL_W-1:0] out_total_r;

  logic [31:0]          in_page32;
  logic [31:0]          fiu32;
  logic [31:0]          n32;
  logic [CNT_W-1:0]     n_act;
  logic [IDX_W-1:0]     h_eff;
  logic                 fire;

  clk_pr_pkg::chain_t   chain [FRAMES+1];
  clk_pr_pkg::chain_t   sel   [FRAMES];
  logic [PAGE_BITS-1:0] cell_page [FRAMES];

  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     emp_idx;
  logic [IDX_W-1:0]     hi_idx;
  logic [IDX_W-1:0]     cand_idx;
  logic [PAGE_BITS-1:0] vic_page;
  logic [IDX_W-1:0]     victim;
  clk_pr_pkg::cmd_t     cmd;
  logic [CNT_W-1:0]     vic_next;
  logic [31:0]          frame32;
  logic [31:0]          evp32;

  // Page number masked to the stored width.
  assign in_page32 = 32'(in_page);

  // Active frame count: zero acts as one, large values saturate to FRAMES.
  assign fiu32 = 32'(fiu_r);
  always_comb begin
    if (fiu32 == 32'd0) begin
      n32 = 32'd1;
    end else if (fiu32 > 32'(FRAMES)) begin
      n32 = 32'(FRAMES);
    end else begin
      n32 = fiu32;
    end
  end
  assign n_act = n32[CNT_W-1:0];

  // The hand restarts at frame 0 when it lies outside the active range.
  assign h_eff = (CNT_W'(hand_r) >= n_act) ? '0 : hand_r;

  // Row of frame cells with the search flags rippling from frame 0 upward.
  assign chain[0] = '0;
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    clk_pr_cell #(
      .INDEX (g),
      .PB    (PAGE_BITS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1]),
      .sel_o    (sel[g]),
      .page_o   (cell_page[g]),
      .req_page (req_page_r),
      .n_act    (n_act),
      .hand     (h_eff),
      .victim   (victim),
      .cmd      (cmd)
    );
  end

  // Encode the one-hot winners of each search into frame numbers.
  always_comb begin
    hit_idx  = '0;
    emp_idx  = '0;
    hi_idx   = '0;
    cand_idx = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (sel[k].hit)  hit_idx  = hit_idx  | IDX_W'(k);
      if (sel[k].emp)  emp_idx  = emp_idx  | IDX_W'(k);
      if (sel[k].hi)   hi_idx   = hi_idx   | IDX_W'(k);
      if (sel[k].cand) cand_idx = cand_idx | IDX_W'(k);
    end
  end

  // Choose the frame that serves this request and the row update.
  always_comb begin
    cmd.upd     = fire;
    cmd.no_cand = 1'b0;
    if (chain[FRAMES].hit) begin
      cmd.op = clk_pr_pkg::OP_HIT;
      victim = hit_idx;
    end else if (chain[FRAMES].emp) begin
      cmd.op = clk_pr_pkg::OP_FILL;
      victim = emp_idx;
    end else begin
      cmd.op = clk_pr_pkg::OP_EVICT;
      if (chain[FRAMES].hi) begin
        victim = hi_idx;
      end else if (chain[FRAMES].cand) begin
        victim = cand_idx;
      end else begin
        victim      = h_eff;
        cmd.no_cand = 1'b1;
      end
    end
  end

  // Page held by the victim frame before replacement.
  always_comb begin
    vic_page = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (IDX_W'(k) == victim) vic_page = vic_page | cell_page[k];
    end
  end

  // Hand moves to the frame after the one just filled.
  assign vic_next = CNT_W'(victim) + CNT_W'(1);
  assign hand_nxt = (vic_next == n_act) ? '0 : vic_next[IDX_W-1:0];
  assign fcnt_nxt = (fcnt_r == clk_pr_pkg::TOTAL_MAX) ? fcnt_r : fcnt_r + 1'b1;

  assign frame32 = 32'(victim);
  assign evp32   = 32'(vic_page);

  // A request is worked off once the output register can take its result.
  assign fire     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r       <= clk_pr_pkg::FIU_RESET;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      hand_r      <= '0;
      fcnt_r      <= '0;
    end else begin
      if (cfg_wr_en) fiu_r <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        req_valid_r <= 1'b1;
      end else if (fire) begin
        req_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fire && (cmd.op != clk_pr_pkg::OP_HIT)) begin
        hand_r <= hand_nxt;
        fcnt_r <= fcnt_nxt;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_page_r <= in_page32[PAGE_BITS-1:0];
    if (fire) begin
      out_frame_r <= frame32[clk_pr_pkg::FRAME_W-1:0];
      if (cmd.op == clk_pr_pkg::OP_HIT) begin
        out_fault_r <= 1'b0;
        out_ev_r    <= 1'b0;
        out_evp_r   <= '0;
        out_total_r <= fcnt_r;
      end else begin
        out_fault_r <= 1'b1;
        out_ev_r    <= (cmd.op == clk_pr_pkg::OP_EVICT);
        out_evp_r   <= (cmd.op == clk_pr_pkg::OP_EVICT) ?
                       evp32[clk_pr_pkg::PAGE_W-1:0] : '0;
        out_total_r <= fcnt_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_evp_r;
  assign out_fault_total   = out_total_r;

endmodule

/* verif/tb_clock_page_replacement.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the second-chance clock page replacement block.
// Holds a scoreboard class that predicts every access; depends on clk_pr_pkg.

// One expected or observed access result.
typedef struct packed {
  logic                           fault;
  logic [clk_pr_pkg::FRAME_W-1:0] frame;
  logic                           ev_valid;
  logic [clk_pr_pkg::PAGE_W-1:0]  ev_page;
  logic [clk_pr_pkg::TOTAL_W-1:0] total;
} access_result_t;

// Keeps a private copy of the frame table and queues expected results.
class replacement_board;
  logic [clk_pr_pkg::PAGE_W-1:0]  page_of [clk_pr_pkg::FRAMES_DEF];
  bit                             held [clk_pr_pkg::FRAMES_DEF];
  bit                             ref_bit [clk_pr_pkg::FRAMES_DEF];
  int                             hand;
  logic [clk_pr_pkg::TOTAL_W-1:0] faults;
  logic [clk_pr_pkg::CFG_W-1:0]   frames_reg;
  access_result_t                 expected_q [$];
  int                             errors;

  function new();
    foreach (held[i]) begin
      held[i] = 0;
      ref_bit[i] = 0;
      page_of[i] = '0;
    end
    hand = 0;
    faults = '0;
    frames_reg = clk_pr_pkg::FIU_RESET;
    errors = 0;
  endfunction

  function void set_frames(logic [clk_pr_pkg::CFG_W-1:0] v);
    frames_reg = v;
  endfunction

  // A count of zero acts as one; anything above the frame row saturates.
  function int active_frames();
    if (frames_reg == 0) return 1;
    if (frames_reg > clk_pr_pkg::FRAMES_DEF) return clk_pr_pkg::FRAMES_DEF;
    return int'(frames_reg);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Predicts the result of one accepted request and updates the table.
  function void note_request(logic [clk_pr_pkg::PAGE_W-1:0] pg);
    access_result_t r;
    int n;
    int slot;
    int h;
    bit found;
    n = active_frames();
    r = '0;
    slot = 0;
    found = 0;

    // Hit search: the lowest matching active frame wins.
    for (int i = 0; i < n && !found; i++) begin
      if (held[i] && page_of[i] == pg) begin
        ref_bit[i] = 1;
        slot = i;
        found = 1;
      end
    end
    if (found) begin
      r.frame = slot[clk_pr_pkg::FRAME_W-1:0];
      r.total = faults;
      expected_q.push_back(r);
      return;
    end

    // Fill the lowest empty active frame if there is one.
    for (int i = 0; i < n && !found; i++) begin
      if (!held[i]) begin
        slot = i;
        found = 1;
      end
    end

    // Otherwise sweep the hand, giving referenced frames a second chance.
    if (!found) begin
      h = hand;
      if (h >= n) h = 0;
      while (ref_bit[h]) begin
        ref_bit[h] = 0;
        h = (h + 1) % n;
      end
      slot = h;
      r.ev_valid = 1;
      r.ev_page = page_of[slot];
    end

    page_of[slot] = pg;
    held[slot] = 1;
    ref_bit[slot] = 1;
    hand = (slot + 1) % n;
    if (faults != clk_pr_pkg::TOTAL_MAX) faults++;

    r.fault = 1;
    r.frame = slot[clk_pr_pkg::FRAME_W-1:0];
    r.total = faults;
    expected_q.push_back(r);
  endfunction

  // Compares one observed result with the oldest expectation.
  function void check_result(access_result_t got);
    access_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected result: frame %0d, fault %0d", got.frame, got.fault);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.fault !== exp_r.fault) begin
      $error("fault: expected %0d, actual %0d", exp_r.fault, got.fault);
      errors++;
    end
    if (got.frame !== exp_r.frame) begin
      $error("frame: expected %0d, actual %0d", exp_r.frame, got.frame);
      errors++;
    end
    if (got.ev_valid !== exp_r.ev_valid) begin
      $error("evicted_valid: expected %0d, actual %0d", exp_r.ev_valid, got.ev_valid);
      errors++;
    end
    if (got.ev_page !== exp_r.ev_page) begin
      $error("evicted_page: expected %h, actual %h", exp_r.ev_page, got.ev_page);
      errors++;
    end
    if (got.total !== exp_r.total) begin
      $error("fault_total: expected %0d, actual %0d", exp_r.total, got.total);
      errors++;
    end
  endfunction
endclass

module tb_clock_page_replacement;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 83;
  localparam int LONG_HOLD   = 80;

  localparam int CFG_W   = clk_pr_pkg::CFG_W;
  localparam int PAGE_W  = clk_pr_pkg::PAGE_W;
  localparam int FRAME_W = clk_pr_pkg::FRAME_W;
  localparam int TOTAL_W = clk_pr_pkg::TOTAL_W;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [PAGE_W-1:0]  in_page;
  logic               out_valid;
  logic               out_stall;
  logic               out_fault;
  logic [FRAME_W-1:0] out_frame;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [TOTAL_W-1:0] out_fault_total;

  replacement_board board;
  int send_gap_max = 6;
  int take_gap_max = 6;
  int long_hold = 0;
  logic [PAGE_W-1:0] pool [$];

  clock_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fault         (out_fault),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one request after a random gap and waits until it is taken.
  // Valid stays high when the next request follows without a gap.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page <= pg;
    do @(posedge clk); while (in_stall);
    board.note_request(pg);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_frames(v);
    @(posedge clk);
  endtask

  // Mostly pages from a small working set so that hits and evictions mix;
  // the rest are the page extremes or fully random pages.
  function automatic logic [PAGE_W-1:0] pick_page();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return pool[$urandom_range(0, pool.size() - 1)];
    if (roll < 85) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return PAGE_W'($urandom_range(0, 65535));
  endfunction

  // One random phase at a fixed active frame count.
  task automatic run_phase(input logic [CFG_W-1:0] setting, input int idx);
    int n;
    settle();
    write_frames(setting);
    n = board.active_frames();
    pool.delete();
    repeat (n + n / 2 + 1) pool.push_back(PAGE_W'($urandom_range(0, 65535)));
    send_gap_max = (idx % 4 == 3) ? 0 : 6;
    take_gap_max = (idx % 4 == 1) ? 0 : 6;
    if (idx == 2) begin
      // Receiver holds off while requests keep coming, so the block backs up.
      long_hold = LONG_HOLD;
      send_gap_max = 0;
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (idx == 4 && i == PHASE_ITEMS / 2) settle();
      send_page(pick_page());
    end
  endtask

  // Result side: a random stall before each result, or one long hold-off.
  initial begin : result_taker
    int k;
    out_stall <= 1'b0;
    forever begin
      if (long_hold > 0) begin
        k = long_hold;
        long_hold = 0;
      end else begin
        k = $urandom_range(0, take_gap_max);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Check every result taken at an edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result('{out_fault, out_frame, out_evicted_valid,
                           out_evicted_page, out_fault_total});
    end
  end

  // Ends the run if neither side moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_flow
    board = new();
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_page <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill from empty, then hit the first two frames.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0000);
    send_page(16'hFFFF);

    // Lower the count below the hand: the sweep restarts at frame 0 and the
    // page left in an inactive frame no longer hits.
    settle();
    write_frames(5'd3);
    send_page(16'h1234);
    send_page(16'hAAAA);
    send_page(16'h0F0F);

    // Raise it again: the page now sits twice and the lowest copy hits.
    settle();
    write_frames(5'd16);
    send_page(16'hAAAA);
    send_page(16'h4321);
    send_page(16'h1234);

    // A count of zero acts as a single frame.
    settle();
    write_frames(5'd0);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0002);

    // Counts above the frame row saturate.
    settle();
    write_frames(5'd31);
    send_page(16'h8000);
    send_page(16'h7FFF);
    send_page(16'hAAAA);
    settle();
    write_frames(5'd17);
    send_page(16'h0000);
    send_page(16'hFFFF);

    // Random phases over a spread of frame counts, extremes included.
    run_phase(5'd16, 0);
    run_phase(5'd1, 1);
    run_phase(5'd2, 2);
    run_phase(5'd5, 3);
    run_phase(5'd8, 4);
    run_phase(5'd31, 5);
    run_phase(5'd0, 6);
    run_phase(CFG_W'($urandom_range(1, 16)), 7);
    run_phase(5'd12, 8);
    run_phase(5'd16, 9);

    settle();
    repeat (5) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/clk_pr_pkg.sv
hdl/clk_pr_cell.sv
hdl/clock_page_replacement.sv
verif/tb_clock_page_replacement.sv
